// ----- hdl/onewire_master_with_rom_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// Single-wire bus master: assertion macros
// Shared checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_MASTER_WITH_ROM_SEARCH_TOP_DEFINES_SVH
`define ONEWIRE_MASTER_WITH_ROM_SEARCH_TOP_DEFINES_SVH

// implication checked on every clock edge outside reset
`define OW_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the next cycle
`define OW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/owm_pkg.sv -----
// ----------------------------------------------------------------------------
// Single-wire bus master package
// Codes, register indexes and types shared by the block.
// ----------------------------------------------------------------------------
package owm_pkg;

    localparam int ROM_BYTES_DEF = 8;

    // commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_RESET  = 3'd1;
    localparam logic [2:0] CMD_XFER   = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_MATCH  = 3'd4;
    localparam logic [2:0] CMD_SKIP   = 3'd5;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOPRES  = 2'd1;
    localparam logic [1:0] ST_HUNG    = 2'd2;
    localparam logic [1:0] ST_DATAERR = 2'd3;

    // register indexes
    localparam logic [2:0] REG_RESET_LOW   = 3'd0;
    localparam logic [2:0] REG_PRES_DELAY  = 3'd1;
    localparam logic [2:0] REG_PRES_WINDOW = 3'd2;
    localparam logic [2:0] REG_RESET_HOLD  = 3'd3;
    localparam logic [2:0] REG_SLOT_REL    = 3'd4;
    localparam logic [2:0] REG_SAMPLE_PT   = 3'd5;
    localparam logic [2:0] REG_SLOT_LEN    = 3'd6;
    localparam logic [2:0] REG_GAP         = 3'd7;

    // ROM command bytes
    localparam logic [7:0] BYTE_SEARCH = 8'hF0;
    localparam logic [7:0] BYTE_MATCH  = 8'h55;
    localparam logic [7:0] BYTE_SKIP   = 8'hCC;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_RLOW  = 8'b0000_0010,
        PH_RWAIT = 8'b0000_0100,
        PH_RPRES = 8'b0000_1000,
        PH_RHOLD = 8'b0001_0000,
        PH_RGAP  = 8'b0010_0000,
        PH_SLOT  = 8'b0100_0000,
        PH_SGAP  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [9:0] reset_low;
        logic [7:0] pres_delay;
        logic [7:0] pres_window;
        logic [9:0] reset_hold;
        logic [5:0] slot_release;
        logic [7:0] sample_point;
        logic [7:0] slot_length;
        logic [7:0] gap;
    } timing_t;

endpackage

// ----- hdl/owm_regs.sv -----
// ----------------------------------------------------------------------------
// Single-wire bus master timing registers
// APB write and read of the eight timing registers.
// ----------------------------------------------------------------------------
module owm_regs
    import owm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output timing_t     timing
);

    timing_t     timing_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign timing = timing_reg;

    // write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timing_reg.reset_low    <= 10'd600;
            timing_reg.pres_delay   <= 8'd15;
            timing_reg.pres_window  <= 8'd66;
            timing_reg.reset_hold   <= 10'd480;
            timing_reg.slot_release <= 6'd2;
            timing_reg.sample_point <= 8'd14;
            timing_reg.slot_length  <= 8'd65;
            timing_reg.gap          <= 8'd10;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_RESET_LOW:   timing_reg.reset_low    <= pwdata[9:0];
                REG_PRES_DELAY:  timing_reg.pres_delay   <= pwdata[7:0];
                REG_PRES_WINDOW: timing_reg.pres_window  <= pwdata[7:0];
                REG_RESET_HOLD:  timing_reg.reset_hold   <= pwdata[9:0];
                REG_SLOT_REL:    timing_reg.slot_release <= pwdata[5:0];
                REG_SAMPLE_PT:   timing_reg.sample_point <= pwdata[7:0];
                REG_SLOT_LEN:    timing_reg.slot_length  <= pwdata[7:0];
                REG_GAP:         timing_reg.gap          <= pwdata[7:0];
                default:         timing_reg.gap          <= timing_reg.gap;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (idx)
            REG_RESET_LOW:   prdata = {22'd0, timing_reg.reset_low};
            REG_PRES_DELAY:  prdata = {24'd0, timing_reg.pres_delay};
            REG_PRES_WINDOW: prdata = {24'd0, timing_reg.pres_window};
            REG_RESET_HOLD:  prdata = {22'd0, timing_reg.reset_hold};
            REG_SLOT_REL:    prdata = {26'd0, timing_reg.slot_release};
            REG_SAMPLE_PT:   prdata = {24'd0, timing_reg.sample_point};
            REG_SLOT_LEN:    prdata = {24'd0, timing_reg.slot_length};
            REG_GAP:         prdata = {24'd0, timing_reg.gap};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

// ----- hdl/onewire_master_with_rom_search_top.sv -----
// ----------------------------------------------------------------------------
// Single-wire bus master with ROM search
// Tick-driven bus reset, byte transfer, ROM search and device select.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata {line_level, rom_in, last_discrepancy, data_byte}, tuser command
//  m_axis    out  tdata {next_discrepancy, rom_out, data_out, status, done_res,
//                        busy_res, line_low}
//  apb       in   eight timing registers at byte address 4*i
//
// One item per clock while the output is not stalled: the sequencer advances
// one tick per accepted item and the result is registered. The output register
// holds one result; input is taken whenever that register is empty or being
// emptied. Reset returns the sequencer to idle and the timing registers to their
// defaults.
// ----------------------------------------------------------------------------
`include "onewire_master_with_rom_search_top_defines.svh"

module onewire_master_with_rom_search_top
    import owm_pkg::*;
#(
    parameter int ROM_BYTES = ROM_BYTES_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // [7:0] data_byte, [14:8] last_discrepancy, [78:15] rom_in, [79] line_level
    input  logic [79:0]   s_axis_tdata,
    // [2:0] command
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // [0] line_low, [1] busy_res, [2] done_res, [4:3] status, [12:5] data_out,
    // [76:13] rom_out, [83:77] next_discrepancy
    output logic [87:0]   m_axis_tdata,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int ROM_BITS = ROM_BYTES * 8;
    localparam int BI_W     = $clog2(ROM_BITS + 1);

    timing_t timing;

    owm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .timing  (timing)
    );
    assign pready = 1'b1;

    // input fields
    logic [2:0]          cmd;
    logic [7:0]          in_byte;
    logic [6:0]          in_ld;
    logic [ROM_BITS-1:0] in_rom;
    logic                level;
    assign in_byte = s_axis_tdata[7:0];
    assign in_ld   = s_axis_tdata[14:8];
    assign in_rom  = s_axis_tdata[15 +: ROM_BITS];
    assign level   = s_axis_tdata[79];
    assign cmd     = s_axis_tuser;

    // state
    phase_t              phase_reg, phase_next;
    logic [2:0]          op_reg, op_next;
    logic [9:0]          tick_reg, tick_next;
    logic [BI_W-1:0]     bit_reg, bit_next;
    logic [3:0]          byte_reg, byte_next;
    logic [7:0]          shift_reg, shift_next;
    logic [ROM_BITS-1:0] rom_reg, rom_next;
    logic [ROM_BITS-1:0] prev_reg, prev_next;
    logic                first_reg, first_next;
    logic [6:0]          found_reg, found_next;
    logic [6:0]          start_reg, start_next;
    logic [7:0]          func_reg, func_next;
    logic [1:0]          st_reg, st_next;
    logic                tx_reg, tx_next;
    logic                rx_reg, rx_next;
    logic [1:0]          trip_reg, trip_next;

    logic                out_valid_reg;
    logic [87:0]         out_data_reg;
    logic                accept;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // result of this tick
    logic                r_line, r_done;
    logic [1:0]          r_status;
    logic [7:0]          r_data;
    logic [ROM_BITS-1:0] r_rom;
    logic [6:0]          r_next;

    // per-tick helpers
    logic [9:0]  tick_inc;
    logic [9:0]  d_rlow, d_hold;
    logic [7:0]  d_delay, d_win, d_slot;
    logic [3:0]  nbyte;
    logic [7:0]  sb_new;
    logic [BI_W-1:0] bi_dec;
    logic        sb, sc;
    logic        prevbit;
    logic [6:0]  bit7;
    logic [BI_W-1:0] kidx;
    logic        end_reset;
    logic        slot_end;

    assign d_rlow  = (timing.reset_low == 10'd0)  ? 10'd1 : timing.reset_low;
    assign d_hold  = (timing.reset_hold == 10'd0) ? 10'd1 : timing.reset_hold;
    assign d_delay = (timing.pres_delay == 8'd0)  ? 8'd1  : timing.pres_delay;
    assign d_win   = (timing.pres_window == 8'd0) ? 8'd1  : timing.pres_window;
    assign d_slot  = (timing.slot_length == 8'd0) ? 8'd1  : timing.slot_length;

    // sequencer next state
    always_comb
    begin
        phase_next = phase_reg;  op_next    = op_reg;     tick_next  = tick_reg;
        bit_next   = bit_reg;    byte_next  = byte_reg;   shift_next = shift_reg;
        rom_next   = rom_reg;    prev_next  = prev_reg;   first_next = first_reg;
        found_next = found_reg;  start_next = start_reg;  func_next  = func_reg;
        st_next    = st_reg;     tx_next    = tx_reg;     rx_next    = rx_reg;
        trip_next  = trip_reg;
        r_line = 1'b0; r_done = 1'b0; r_status = ST_OK; r_data = 8'd0;
        r_rom = '0; r_next = 7'd0;
        nbyte = 4'd0; sb_new = 8'd0; sb = 1'b0; sc = 1'b0; prevbit = 1'b0;
        bit7 = 7'd0; kidx = '0; bi_dec = '0;
        end_reset = 1'b0; slot_end = 1'b0;

        // take a command while idle
        if (phase_reg == PH_IDLE && cmd >= CMD_RESET && cmd <= CMD_SKIP)
        begin
            op_next = cmd;
            st_next = ST_OK;
            tick_next = 10'd0;
            if (cmd == CMD_XFER)
            begin
                shift_next = in_byte;
                bit_next   = BI_W'(8);
                tx_next    = in_byte[0];
                rx_next    = in_byte[0];
                phase_next = PH_SLOT;
            end
            else
            begin
                phase_next = PH_RLOW;
                if (cmd == CMD_SEARCH)
                begin
                    start_next = in_ld;
                    prev_next  = in_rom;
                    found_next = 7'd0;
                    rom_next   = '0;
                end
                else if (cmd != CMD_RESET)
                begin
                    func_next = in_byte;
                    prev_next = in_rom;
                end
            end
        end

        tick_inc = tick_next + 10'd1;

        // one tick of the current phase
        unique case (phase_next)
            PH_IDLE: ;
            PH_RLOW:
            begin
                r_line = 1'b1;
                tick_next = tick_inc;
                if (tick_inc >= d_rlow)
                begin
                    phase_next = PH_RWAIT; tick_next = 10'd0;
                end
            end
            PH_RWAIT:
            begin
                tick_next = tick_inc;
                if (tick_inc >= {2'd0, d_delay})
                begin
                    phase_next = PH_RPRES; tick_next = 10'd0;
                end
            end
            PH_RPRES, PH_RHOLD, PH_RGAP:
            begin
                if (phase_next == PH_RPRES)
                begin
                    if (!level)
                    begin
                        phase_next = PH_RHOLD; tick_next = 10'd0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                        if (tick_inc >= {2'd0, d_win})
                        begin
                            st_next = ST_NOPRES; end_reset = 1'b1;
                        end
                    end
                end
                else if (phase_next == PH_RHOLD)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= d_hold)
                    begin
                        if (!level)
                        begin
                            st_next = ST_HUNG; end_reset = 1'b1;
                        end
                        else if (timing.gap == 8'd0)
                            end_reset = 1'b1;
                        else
                        begin
                            phase_next = PH_RGAP; tick_next = 10'd0;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= {2'd0, timing.gap})
                        end_reset = 1'b1;
                end
                // hand over after the reset sequence
                if (end_reset)
                begin
                    tick_next = 10'd0;
                    if (op_next == CMD_RESET)
                    begin
                        phase_next = PH_IDLE; r_done = 1'b1; r_status = st_next;
                    end
                    else if (op_next == CMD_SEARCH && st_next != ST_OK)
                    begin
                        phase_next = PH_IDLE; r_done = 1'b1; r_status = ST_NOPRES;
                    end
                    else
                    begin
                        byte_next  = 4'd0;
                        shift_next = (op_next == CMD_SEARCH) ? BYTE_SEARCH :
                                     (op_next == CMD_MATCH)  ? BYTE_MATCH : BYTE_SKIP;
                        bit_next   = BI_W'(8);
                        tx_next    = shift_next[0];
                        rx_next    = shift_next[0];
                        phase_next = PH_SLOT;
                    end
                end
            end
            PH_SLOT, PH_SGAP:
            begin
                if (phase_next == PH_SLOT)
                begin
                    r_line = ({4'd0, tick_next} < {8'd0, timing.slot_release}) || !tx_next;
                    if (tick_next == {2'd0, timing.sample_point} && !level)
                        rx_next = 1'b0;
                    tick_next = tick_inc;
                    if (tick_inc >= {2'd0, d_slot})
                    begin
                        if (timing.gap == 8'd0)
                            slot_end = 1'b1;
                        else
                        begin
                            phase_next = PH_SGAP; tick_next = 10'd0;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= {2'd0, timing.gap})
                        slot_end = 1'b1;
                end
                // decide the next slot
                if (slot_end)
                begin
                    tick_next = 10'd0;
                    bi_dec = (bit_next == '0) ? '0 : bit_next - BI_W'(1);
                    if (op_next == CMD_SEARCH && byte_next == 4'd1)
                    begin
                        if (trip_next == 2'd0)
                        begin
                            first_next = rx_next; trip_next = 2'd1;
                            tx_next = 1'b1; rx_next = 1'b1; phase_next = PH_SLOT;
                        end
                        else if (trip_next == 2'd1)
                        begin
                            sb = first_next; sc = rx_next;
                            if (sb && sc)
                            begin
                                phase_next = PH_IDLE; r_done = 1'b1; r_status = ST_DATAERR;
                            end
                            else
                            begin
                                bit7 = 7'(bit_next);
                                kidx = BI_W'(ROM_BITS) - bit_next;
                                prevbit = prev_next[kidx[BI_W-2:0]];
                                if (!sb && !sc && bit_next != '0)
                                begin
                                    if (start_next > bit7 || (prevbit && start_next != bit7))
                                    begin
                                        sb = 1'b1; found_next = bit7;
                                    end
                                end
                                rom_next = {sb, rom_next[ROM_BITS-1:1]};
                                trip_next = 2'd2;
                                tx_next = sb; rx_next = sb; phase_next = PH_SLOT;
                            end
                        end
                        else
                        begin
                            bit_next = bi_dec;
                            if (bi_dec == '0)
                            begin
                                phase_next = PH_IDLE; r_done = 1'b1;
                                r_rom = rom_next; r_next = found_next;
                            end
                            else
                            begin
                                trip_next = 2'd0; tx_next = 1'b1; rx_next = 1'b1;
                                phase_next = PH_SLOT;
                            end
                        end
                    end
                    else
                    begin
                        sb_new = {rx_next, shift_next[7:1]};
                        shift_next = sb_new;
                        bit_next = bi_dec;
                        if (bi_dec != '0)
                        begin
                            tx_next = sb_new[0]; rx_next = sb_new[0]; phase_next = PH_SLOT;
                        end
                        else if (op_next == CMD_XFER)
                        begin
                            phase_next = PH_IDLE; r_done = 1'b1; r_data = sb_new;
                        end
                        else if (op_next == CMD_SEARCH)
                        begin
                            byte_next = 4'd1; bit_next = BI_W'(ROM_BITS); trip_next = 2'd0;
                            tx_next = 1'b1; rx_next = 1'b1; phase_next = PH_SLOT;
                        end
                        else
                        begin
                            nbyte = byte_next + 4'd1;
                            byte_next = nbyte;
                            if (op_next == CMD_MATCH && nbyte >= 4'd1 && 
                                {28'd0, nbyte} <= 32'(ROM_BYTES))
                            begin
                                shift_next = prev_next[{nbyte[2:0] - 3'd1, 3'd0} +: 8];
                                bit_next = BI_W'(8);
                                tx_next = shift_next[0]; rx_next = shift_next[0];
                                phase_next = PH_SLOT;
                            end
                            else if ((op_next == CMD_MATCH && {28'd0, nbyte} == 32'(ROM_BYTES + 1))
                                     || (op_next != CMD_MATCH && nbyte == 4'd1))
                            begin
                                shift_next = func_next; bit_next = BI_W'(8);
                                tx_next = func_next[0]; rx_next = func_next[0];
                                phase_next = PH_SLOT;
                            end
                            else
                            begin
                                phase_next = PH_IDLE; r_done = 1'b1; r_status = st_next;
                            end
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE; tick_next = 10'd0;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; op_reg <= 3'd0; tick_reg <= 10'd0; bit_reg <= '0;
            byte_reg <= 4'd0; shift_reg <= 8'd0; rom_reg <= '0; prev_reg <= '0;
            first_reg <= 1'b0; found_reg <= 7'd0; start_reg <= 7'd0; func_reg <= 8'd0;
            st_reg <= 2'd0; tx_reg <= 1'b0; rx_reg <= 1'b0; trip_reg <= 2'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next; op_reg <= op_next; tick_reg <= tick_next;
            bit_reg <= bit_next; byte_reg <= byte_next; shift_reg <= shift_next;
            rom_reg <= rom_next; prev_reg <= prev_next; first_reg <= first_next;
            found_reg <= found_next; start_reg <= start_next; func_reg <= func_next;
            st_reg <= st_next; tx_reg <= tx_next; rx_reg <= rx_next; trip_reg <= trip_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {4'd0, r_next, r_rom, r_data, r_status, r_done,
                             phase_next != PH_IDLE, r_line};
    end

    `OW_ASSERT_IMPL(a_busy_done, m_axis_tvalid && m_axis_tdata[2], !m_axis_tdata[1],
        "done with busy set")
    `OW_ASSERT_NEXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "result dropped under stall")
    `OW_ASSERT_IMPL(a_idle_onehot, 1'b1, $onehot(phase_reg), "phase not one-hot")

endmodule

// ----- bench/onewire_master_with_rom_search_top_tb.sv -----
// ----------------------------------------------------------------------------
// Single-wire bus master testbench
// Streams microsecond ticks and commands into the master while a bus device
// is emulated from the predicted sequencer state. Every result is checked
// field by field against an in-bench predictor over several timing settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module onewire_master_with_rom_search_top_tb;
    import owm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic [6:0]  ldisc;
        logic [63:0] rom;
        int          pres_mode;   // 0 normal, 1 no presence, 2 hung bus
        int          err_pct;     // chance of an 11 pair in the search
    } bus_op_t;

    typedef struct {
        logic        line;
        logic        busy;
        logic        done;
        logic [1:0]  st;
        logic [7:0]  data;
        logic [63:0] rom;
        logic [6:0]  nxt;
    } bus_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // [7:0] data_byte, [14:8] last_discrepancy, [78:15] rom_in, [79] line_level
    logic [79:0]  s_axis_tdata = '0;
    // [2:0] command
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] line_low, [1] busy_res, [2] done_res, [4:3] status, [12:5] data_out,
    // [76:13] rom_out, [83:77] next_discrepancy
    logic [87:0]  m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    onewire_master_with_rom_search_top dut (.*);

    always #2 clk = ~clk;

    // predicted timing registers
    int unsigned t_rlow = 600, t_pdel = 15, t_pwin = 66, t_rhold = 480;
    int unsigned t_srel = 2, t_samp = 14, t_slen = 65, t_gap = 10;

    // predicted sequencer state
    phase_t      ph = PH_IDLE;
    int unsigned opn, tcnt, bidx, byidx, sbyte, fbit, fdisc, sstart, pfunc, sreg;
    int unsigned txb, rxb, trip;
    logic [63:0] rshift, prev_id;
    bus_result_t res;

    bus_op_t     ops[$];
    bus_result_t results_due[$];
    int          errors = 0;
    int          sent = 0;
    int          snd_idle = 29, rcv_idle = 45;
    int          cur_pres = 0, cur_err = 0;
    logic        pair_a = 1'b0, pair_b = 1'b0;
    logic        in_acc = 1'b0;
    logic [2:0]  held_cmd = '0;
    logic [79:0] held_data = '0;
    int          cycles = 0;

    function automatic int unsigned dur(int unsigned x);
        return (x == 0) ? 1 : x;
    endfunction

    function void finish_op(int unsigned st, int unsigned d, logic [63:0] r, int unsigned n);
        ph = PH_IDLE;
        tcnt = 0;
        res.done = 1'b1;
        res.st = st[1:0];
        res.data = d[7:0];
        res.rom = r;
        res.nxt = n[6:0];
    endfunction

    function void start_slot(int unsigned b);
        txb = b & 1;
        rxb = txb;
        ph = PH_SLOT;
        tcnt = 0;
    endfunction

    function void load_byte(int unsigned v);
        sbyte = v & 8'hFF;
        bidx = 8;
        start_slot(sbyte);
    endfunction

    function void reset_over();
        if (opn == CMD_RESET)
            finish_op(sreg, 0, '0, 0);
        else if (opn == CMD_SEARCH)
        begin
            if (sreg != 0)
                finish_op(32'(ST_NOPRES), 0, '0, 0);
            else
            begin
                byidx = 0;
                load_byte(32'(BYTE_SEARCH));
            end
        end
        else
        begin
            byidx = 0;
            load_byte(opn == CMD_MATCH ? 32'(BYTE_MATCH) : 32'(BYTE_SKIP));
        end
    endfunction

    function void byte_over();
        int unsigned lastn;
        if (opn == CMD_XFER)
            finish_op(32'(ST_OK), sbyte, '0, 0);
        else if (opn == CMD_SEARCH)
        begin
            byidx = 1;
            bidx = 64;
            trip = 0;
            start_slot(1);
        end
        else
        begin
            byidx = (byidx + 1) & 4'hF;
            lastn = (opn == CMD_MATCH) ? 9 : 1;
            if (opn == CMD_MATCH && byidx >= 1 && byidx <= 8)
                load_byte(32'(prev_id[8*(byidx-1) +: 8]));
            else if (byidx == lastn)
                load_byte(pfunc);
            else
                finish_op(sreg, 0, '0, 0);
        end
    endfunction

    function void slot_over();
        int unsigned b, c;
        if (opn == CMD_SEARCH && byidx == 1)
        begin
            if (trip == 0)
            begin
                fbit = rxb;
                trip = 1;
                start_slot(1);
            end
            else if (trip == 1)
            begin
                b = fbit;
                c = rxb;
                if (b == 1 && c == 1)
                begin
                    finish_op(32'(ST_DATAERR), 0, '0, 0);
                    return;
                end
                // discrepancy: pick 1 below the start point, or where the old id had it but not at the start point
                if (b == 0 && c == 0 && bidx >= 1 && bidx <= 64)
                begin
                    if (sstart > bidx || (prev_id[64-bidx] && sstart != bidx))
                    begin
                        b = 1;
                        fdisc = bidx;
                    end
                end
                rshift = {b[0], rshift[63:1]};
                trip = 2;
                start_slot(b);
            end
            else
            begin
                bidx = (bidx == 0) ? 0 : bidx - 1;
                if (bidx == 0)
                    finish_op(32'(ST_OK), 0, rshift, fdisc);
                else
                begin
                    trip = 0;
                    start_slot(1);
                end
            end
            return;
        end
        sbyte = ((sbyte >> 1) | (rxb << 7)) & 8'hFF;
        bidx = (bidx == 0) ? 0 : bidx - 1;
        if (bidx > 0)
            start_slot(sbyte & 1);
        else
            byte_over();
    endfunction

    // advance the predictor by one accepted item and queue its result
    function void bus_tick(logic [2:0] cmd, logic [79:0] d);
        logic lv;
        lv = d[79];
        res = '{default: '0};
        if (ph == PH_IDLE && cmd >= CMD_RESET && cmd <= CMD_SKIP)
        begin
            opn = 32'(cmd);
            sreg = 0;
            if (cmd == CMD_XFER)
                load_byte(32'(d[7:0]));
            else
            begin
                ph = PH_RLOW;
                tcnt = 0;
                if (cmd == CMD_SEARCH)
                begin
                    sstart = 32'(d[14:8]);
                    prev_id = d[78:15];
                    fdisc = 0;
                    rshift = '0;
                end
                else if (cmd >= CMD_MATCH)
                begin
                    pfunc = 32'(d[7:0]);
                    prev_id = d[78:15];
                end
            end
        end
        case (ph)
            PH_RLOW:
            begin
                res.line = 1'b1;
                tcnt++;
                if (tcnt >= dur(t_rlow))
                begin
                    ph = PH_RWAIT;
                    tcnt = 0;
                end
            end
            PH_RWAIT:
            begin
                tcnt++;
                if (tcnt >= dur(t_pdel))
                begin
                    ph = PH_RPRES;
                    tcnt = 0;
                end
            end
            PH_RPRES:
            begin
                if (!lv)
                begin
                    ph = PH_RHOLD;
                    tcnt = 0;
                end
                else
                begin
                    tcnt++;
                    if (tcnt >= dur(t_pwin))
                    begin
                        sreg = 32'(ST_NOPRES);
                        reset_over();
                    end
                end
            end
            PH_RHOLD:
            begin
                tcnt++;
                if (tcnt >= dur(t_rhold))
                begin
                    if (!lv)
                    begin
                        sreg = 32'(ST_HUNG);
                        reset_over();
                    end
                    else if (t_gap == 0)
                        reset_over();
                    else
                    begin
                        ph = PH_RGAP;
                        tcnt = 0;
                    end
                end
            end
            PH_RGAP:
            begin
                tcnt++;
                if (tcnt >= t_gap)
                    reset_over();
            end
            PH_SLOT:
            begin
                res.line = (tcnt < t_srel || txb == 0);
                if (tcnt == t_samp && !lv)
                    rxb = 0;
                tcnt++;
                if (tcnt >= dur(t_slen))
                begin
                    if (t_gap == 0)
                        slot_over();
                    else
                    begin
                        ph = PH_SGAP;
                        tcnt = 0;
                    end
                end
            end
            PH_SGAP:
            begin
                tcnt++;
                if (tcnt >= t_gap)
                    slot_over();
            end
            default: ;
        endcase
        tcnt &= 10'h3FF;
        res.busy = (ph != PH_IDLE);
        results_due.push_back(res);
    endfunction

    // emulate the bus device for the next tick from the predicted state
    function logic device_level();
        logic lv;
        lv = 1'($urandom_range(0, 1));
        case (ph)
            PH_RPRES: lv = (cur_pres == 1) ? 1'b1 : ($urandom_range(0, 9) >= 6);
            PH_RHOLD:
            begin
                if (tcnt + 1 >= dur(t_rhold))
                    lv = (cur_pres != 2);
            end
            PH_SLOT:
            begin
                if (opn == CMD_SEARCH && byidx == 1 && tcnt == t_samp)
                begin
                    if (trip == 0)
                    begin
                        if ($urandom_range(0, 99) < cur_err)
                        begin
                            pair_a = 1'b1;
                            pair_b = 1'b1;
                        end
                        else
                        begin
                            case ($urandom_range(0, 2))
                                0:
                                begin
                                    pair_a = 1'b0;
                                    pair_b = 1'b1;
                                end
                                1:
                                begin
                                    pair_a = 1'b1;
                                    pair_b = 1'b0;
                                end
                                default:
                                begin
                                    pair_a = 1'b0;
                                    pair_b = 1'b0;
                                end
                            endcase
                        end
                        lv = pair_a;
                    end
                    else if (trip == 1)
                        lv = pair_b;
                end
            end
            default: ;
        endcase
        return lv;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // capture handshakes and check results
    always @(posedge clk)
    begin
        bus_result_t w;
        logic [87:0] g;
        in_acc <= s_axis_tvalid && s_axis_tready;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            g = m_axis_tdata;
            if (results_due.size() == 0)
                report_mismatch("unexpected item", g[63:0], '0);
            else
            begin
                w = results_due.pop_front();
                if (g[0] !== w.line)
                    report_mismatch("line_low", 64'(g[0]), 64'(w.line));
                if (g[1] !== w.busy)
                    report_mismatch("busy_res", 64'(g[1]), 64'(w.busy));
                if (g[2] !== w.done)
                    report_mismatch("done_res", 64'(g[2]), 64'(w.done));
                if (g[4:3] !== w.st)
                    report_mismatch("status", 64'(g[4:3]), 64'(w.st));
                if (g[12:5] !== w.data)
                    report_mismatch("data_out", 64'(g[12:5]), 64'(w.data));
                if (g[76:13] !== w.rom)
                    report_mismatch("rom_out", g[76:13], w.rom);
                if (g[83:77] !== w.nxt)
                    report_mismatch("next_discrepancy", 64'(g[83:77]), 64'(w.nxt));
            end
        end
    end

    // drive ticks and commands; predict each item once it has been taken
    always @(negedge clk)
    begin
        logic        hold, nv;
        logic [2:0]  c;
        logic [79:0] d;
        bus_op_t     op;
        if (rst_n)
        begin
            hold = s_axis_tvalid;
            if (in_acc)
            begin
                bus_tick(held_cmd, held_data);
                hold = 1'b0;
            end
            nv = hold;
            c = held_cmd;
            d = held_data;
            if (!hold && (ph != PH_IDLE || ops.size() > 0)
                && $urandom_range(0, 99) >= snd_idle)
            begin
                nv = 1'b1;
                d = {1'b0, {$urandom, $urandom}, 7'($urandom_range(0, 65)), 8'($urandom)};
                c = CMD_TICK;
                if (ph != PH_IDLE)
                begin
                    // stray commands while busy are ignored
                    if ($urandom_range(0, 9) == 0)
                        c = 3'($urandom_range(0, 7));
                end
                else if ($urandom_range(0, 99) < 15)
                    c = ($urandom_range(0, 2) == 0) ? CMD_TICK : 3'($urandom_range(6, 7));
                else
                begin
                    op = ops.pop_front();
                    c = op.cmd;
                    d = {1'b0, op.rom, op.ldisc, op.data};
                    cur_pres = op.pres_mode;
                    cur_err = op.err_pct;
                end
                d[79] = device_level();
                sent++;
            end
            held_cmd <= c;
            held_data <= d;
            s_axis_tuser <= c;
            s_axis_tdata <= d;
            s_axis_tvalid <= nv;
            m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);
        end
    end

    // wait until nothing is queued, in flight or owed
    task automatic drain();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (ops.size() > 0 || s_axis_tvalid || ph != PH_IDLE || results_due.size() > 0);
    endtask

    task automatic reg_write(logic [2:0] idx, int unsigned val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_RESET_LOW:   t_rlow = val & 10'h3FF;
            REG_PRES_DELAY:  t_pdel = val & 8'hFF;
            REG_PRES_WINDOW: t_pwin = val & 8'hFF;
            REG_RESET_HOLD:  t_rhold = val & 10'h3FF;
            REG_SLOT_REL:    t_srel = val & 6'h3F;
            REG_SAMPLE_PT:   t_samp = val & 8'hFF;
            REG_SLOT_LEN:    t_slen = val & 8'hFF;
            default:         t_gap = val & 8'hFF;
        endcase
    endtask

    // read one register and compare against the predicted value
    task automatic reg_check(logic [2:0] idx, int unsigned want);
        logic [31:0] got;
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        if (got !== want)
            report_mismatch("prdata", 64'(got), 64'(want));
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    task automatic check_regs();
        reg_check(REG_RESET_LOW, t_rlow);
        reg_check(REG_PRES_DELAY, t_pdel);
        reg_check(REG_PRES_WINDOW, t_pwin);
        reg_check(REG_RESET_HOLD, t_rhold);
        reg_check(REG_SLOT_REL, t_srel);
        reg_check(REG_SAMPLE_PT, t_samp);
        reg_check(REG_SLOT_LEN, t_slen);
        reg_check(REG_GAP, t_gap);
    endtask

    task automatic set_timing(int unsigned rl, int unsigned pd, int unsigned pw,
                              int unsigned rh, int unsigned sr, int unsigned sp,
                              int unsigned sl, int unsigned gp);
        drain();
        reg_write(REG_RESET_LOW, rl);
        reg_write(REG_PRES_DELAY, pd);
        reg_write(REG_PRES_WINDOW, pw);
        reg_write(REG_RESET_HOLD, rh);
        reg_write(REG_SLOT_REL, sr);
        reg_write(REG_SAMPLE_PT, sp);
        reg_write(REG_SLOT_LEN, sl);
        reg_write(REG_GAP, gp);
    endtask

    task automatic add_op(logic [2:0] cmd, logic [7:0] data, logic [6:0] ld,
                          logic [63:0] rom, int pres, int err);
        bus_op_t op;
        op = '{cmd, data, ld, rom, pres, err};
        ops.push_back(op);
    endtask

    initial
    begin
        int mode, target, cmd_r;
        logic [63:0] r;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values and register widths by read-back
        check_regs();
        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        check_regs();

        // short timing: presence cases, byte extremes and skip select
        set_timing(2, 1, 3, 2, 1, 2, 4, 1);
        add_op(CMD_RESET, 8'hFF, 7'd0, '0, 0, 0);
        add_op(CMD_RESET, 8'h00, 7'd0, '0, 1, 0);
        add_op(CMD_RESET, 8'h00, 7'd0, '0, 2, 0);
        add_op(CMD_XFER, 8'h00, 7'd0, '0, 0, 0);
        add_op(CMD_XFER, 8'hFF, 7'd0, '0, 0, 0);
        add_op(CMD_XFER, 8'hA5, 7'd0, '0, 0, 0);
        add_op(CMD_SKIP, 8'h44, 7'd0, '0, 0, 0);
        add_op(CMD_SKIP, 8'hBE, 7'd0, '0, 2, 0);

        // one-tick slots: search and match select
        set_timing(1, 0, 3, 1, 0, 0, 1, 0);
        r = {$urandom, $urandom};
        add_op(CMD_SEARCH, 8'h00, 7'd65, '0, 0, 0);
        add_op(CMD_SEARCH, 8'h00, 7'd32, r, 0, 0);
        add_op(CMD_SEARCH, 8'h00, 7'd1, '1, 0, 100);
        add_op(CMD_SEARCH, 8'h00, 7'd65, '0, 1, 0);
        add_op(CMD_MATCH, 8'h3C, 7'd0, r, 0, 0);
        add_op(CMD_MATCH, 8'hC3, 7'd0, ~r, 1, 0);

        // all-zero registers: one-tick durations and no gaps
        set_timing(0, 0, 0, 0, 0, 0, 0, 0);
        add_op(CMD_XFER, 8'h96, 7'd0, '0, 0, 0);
        add_op(CMD_RESET, 8'h00, 7'd0, '0, 0, 0);
        // sample point past the slot end, then release past the slot end
        set_timing(1, 1, 2, 1, 1, 200, 4, 0);
        add_op(CMD_XFER, 8'h69, 7'd0, '0, 0, 0);
        set_timing(1, 1, 2, 1, 10, 1, 4, 2);
        add_op(CMD_XFER, 8'hF0, 7'd0, '0, 0, 0);

        // random part under three idling patterns
        for (mode = 0; mode < 3; mode++)
        begin
            drain();
            snd_idle = (mode == 0) ? 29 : (mode == 1) ? 45 : 0;
            rcv_idle = (mode == 0) ? 45 : (mode == 1) ? 29 : 0;
            target = sent + 140;
            while (sent < target)
            begin
                cmd_r = $urandom_range(1, 5);
                if (cmd_r == CMD_SEARCH || cmd_r == CMD_MATCH)
                    set_timing(1, 0, 3, 1, 0, 0, 1, 0);
                else if ($urandom_range(0, 1) == 0)
                    set_timing($urandom_range(0, 4), $urandom_range(0, 3),
                               $urandom_range(1, 4), $urandom_range(0, 4),
                               $urandom_range(0, 3), $urandom_range(0, 5),
                               $urandom_range(1, 5), $urandom_range(0, 2));
                add_op(3'(cmd_r), 8'($urandom),
                       ($urandom_range(0, 2) == 0) ? 7'd65 : 7'($urandom_range(0, 65)),
                       {$urandom, $urandom},
                       ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2),
                       ($urandom_range(0, 3) == 0) ? 3 : 0);
                drain();
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/owm_pkg.sv
hdl/owm_regs.sv
hdl/onewire_master_with_rom_search_top.sv
bench/onewire_master_with_rom_search_top_tb.sv
